FILE: rtl/core/sync_length_checksum_deframer_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sync/length/checksum deframer
// Property shorthands used by the sldf_engine module.
// ----------------------------------------------------------------------------
`ifndef SYNC_LENGTH_CHECKSUM_DEFRAMER_MACROS_SVH
`define SYNC_LENGTH_CHECKSUM_DEFRAMER_MACROS_SVH

// same-cycle implication
`define SLDF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sldf assertion failed");

// next-cycle implication
`define SLDF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sldf assertion failed");

`endif

FILE: rtl/core/sldf_pkg.sv
// ----------------------------------------------------------------------------
// sldf_pkg
// Types and constants of the sync/length/checksum deframer.
// ----------------------------------------------------------------------------
package sldf_pkg;

  typedef enum logic [1:0] {
    MODE_PUSH    = 2'd0,
    MODE_READ    = 2'd1,
    MODE_RELEASE = 2'd2,
    MODE_NOP     = 2'd3
  } mode_t;

  localparam logic [8:0]  FRAME_OVERHEAD = 9'd5;
  localparam logic [15:0] HEADER_RESET   = 16'hAA55;

  typedef struct packed {
    logic       overflow;
    logic [7:0] read_data;
    logic [7:0] frame_length;
    logic       frame_ready;
  } res_t;

endpackage

FILE: rtl/core/sldf_store.sv
// ----------------------------------------------------------------------------
// sldf_store
// Byte store: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module sldf_store #(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr0,
  input  logic [AW-1:0] rd_addr1,
  output logic [7:0]    rd_data0,
  output logic [7:0]    rd_data1
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data0 <= mem[rd_addr0];
    rd_data1 <= mem[rd_addr1];
  end

endmodule

FILE: rtl/core/sldf_engine.sv
// ----------------------------------------------------------------------------
// sldf_engine
// Circular-store bookkeeping and frame scan sequencer.
// ----------------------------------------------------------------------------
`include "sync_length_checksum_deframer_macros.svh"

module sldf_engine #(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [15:0]      hdr_word,
  input  logic             op_start,
  input  sldf_pkg::mode_t  op_mode,
  input  logic [7:0]       op_byte,
  input  logic [7:0]       op_idx,
  output logic             idle,
  output logic             done,
  output sldf_pkg::res_t   res,
  output logic             wr_en,
  output logic [AW-1:0]    wr_addr,
  output logic [7:0]       wr_data,
  output logic [AW-1:0]    rd_addr0,
  output logic [AW-1:0]    rd_addr1,
  input  logic [7:0]       rd_data0,
  input  logic [7:0]       rd_data1
);
  import sldf_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int OW = CW + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_HDR_ISSUE, S_HDR_CHK, S_LEN_CHK, S_SUM_ISSUE, S_SUM_ADD, S_CK_CHK, S_DONE
  } state_t;

  state_t        state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [CW-1:0] start_r, start_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic          held_r, held_nxt;
  logic [7:0]    len_r, len_nxt;
  logic [8:0]    i_r, i_nxt;
  logic [15:0]   sum_r, sum_nxt;
  logic          ovf_r, ovf_nxt;
  logic [7:0]    rdata_r, rdata_nxt;
  logic [OW-1:0] rel_cnt;
  logic [OW-1:0] remain;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [OW-1:0] l);
    logic [OW:0] s;
    s = (OW+1)'(head) + (OW+1)'(l);
    if (s >= (OW+1)'(DEPTH)) begin
      s = s - (OW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign rel_cnt = OW'(start_r) + OW'(FRAME_OVERHEAD) + OW'(len_r);
  assign remain  = OW'(fill_r) - OW'(pos_r);

  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    fill_nxt  = fill_r;
    start_nxt = start_r;
    pos_nxt   = pos_r;
    held_nxt  = held_r;
    len_nxt   = len_r;
    i_nxt     = i_r;
    sum_nxt   = sum_r;
    ovf_nxt   = ovf_r;
    rdata_nxt = rdata_r;
    wr_en     = 1'b0;
    wr_addr   = phys(head_r, OW'(fill_r));
    wr_data   = op_byte;
    rd_addr0  = phys(head_r, OW'(pos_r));
    rd_addr1  = phys(head_r, OW'(pos_r) + OW'(1));

    unique case (state_r)
      S_IDLE: begin
        if (op_start) begin
          ovf_nxt   = 1'b0;
          rdata_nxt = 8'd0;
          pos_nxt   = '0;
          unique case (op_mode)
            MODE_PUSH: begin
              if (fill_r >= CW'(DEPTH)) begin
                ovf_nxt = 1'b1;
              end else begin
                wr_en    = 1'b1;
                fill_nxt = fill_r + CW'(1);
              end
              state_nxt = held_r ? S_DONE : S_HDR_ISSUE;
            end
            MODE_READ: begin
              rd_addr0  = phys(head_r, OW'(start_r) + OW'(3) + OW'(op_idx));
              state_nxt = (held_r && (op_idx < len_r)) ? S_SUM_ADD : S_DONE;
            end
            MODE_RELEASE: begin
              if (held_r) begin
                head_nxt  = phys(head_r, rel_cnt);
                fill_nxt  = CW'(OW'(fill_r) - rel_cnt);
                held_nxt  = 1'b0;
                start_nxt = '0;
              end
              state_nxt = S_HDR_ISSUE;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_HDR_ISSUE: begin
        if (OW'(pos_r) + OW'(1) >= OW'(fill_r)) begin
          head_nxt  = phys(head_r, OW'(pos_r));
          fill_nxt  = fill_r - pos_r;
          start_nxt = '0;
          held_nxt  = 1'b0;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_HDR_CHK;
        end
      end
      S_HDR_CHK: begin
        rd_addr0 = phys(head_r, OW'(pos_r) + OW'(2));
        if ({rd_data1, rd_data0} != hdr_word) begin
          pos_nxt   = pos_r + CW'(1);
          state_nxt = S_HDR_ISSUE;
        end else if (remain < OW'(FRAME_OVERHEAD)) begin
          head_nxt  = phys(head_r, OW'(pos_r));
          fill_nxt  = fill_r - pos_r;
          start_nxt = '0;
          held_nxt  = 1'b0;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_LEN_CHK;
        end
      end
      S_LEN_CHK: begin
        len_nxt = rd_data0;
        if (remain < OW'(FRAME_OVERHEAD) + OW'(rd_data0)) begin
          head_nxt  = phys(head_r, OW'(pos_r));
          fill_nxt  = fill_r - pos_r;
          start_nxt = '0;
          held_nxt  = 1'b0;
          state_nxt = S_DONE;
        end else begin
          sum_nxt   = 16'(rd_data0);
          i_nxt     = 9'd1;
          state_nxt = S_SUM_ISSUE;
        end
      end
      S_SUM_ISSUE: begin
        if (i_r > {1'b0, len_r}) begin
          rd_addr0  = phys(head_r, OW'(pos_r) + OW'(3) + OW'(len_r));
          rd_addr1  = phys(head_r, OW'(pos_r) + OW'(4) + OW'(len_r));
          state_nxt = S_CK_CHK;
        end else begin
          rd_addr0  = phys(head_r, OW'(pos_r) + OW'(2) + OW'(i_r));
          state_nxt = S_SUM_ADD;
        end
      end
      S_SUM_ADD: begin
        // also the wait state of a payload read
        if (held_r) begin
          rdata_nxt = rd_data0;
          state_nxt = S_DONE;
        end else begin
          sum_nxt   = sum_r + 16'(rd_data0);
          i_nxt     = i_r + 9'd1;
          state_nxt = S_SUM_ISSUE;
        end
      end
      S_CK_CHK: begin
        if ({rd_data1, rd_data0} == sum_r) begin
          held_nxt  = 1'b1;
          start_nxt = pos_r;
          state_nxt = S_DONE;
        end else begin
          pos_nxt   = pos_r + CW'(1);
          state_nxt = S_HDR_ISSUE;
        end
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      fill_r  <= '0;
      start_r <= '0;
      held_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      fill_r  <= fill_nxt;
      start_r <= start_nxt;
      held_r  <= held_nxt;
    end
    pos_r   <= pos_nxt;
    len_r   <= len_nxt;
    i_r     <= i_nxt;
    sum_r   <= sum_nxt;
    ovf_r   <= ovf_nxt;
    rdata_r <= rdata_nxt;
  end

  assign idle             = (state_r == S_IDLE);
  assign done             = (state_r == S_DONE);
  assign res.frame_ready  = held_r;
  assign res.frame_length = held_r ? len_r : 8'd0;
  assign res.read_data    = rdata_r;
  assign res.overflow     = ovf_r;

  `SLDF_ASSERT_IMP(a_fill_bound, clk, rst_n, 1'b1, fill_r <= CW'(DEPTH))
  `SLDF_ASSERT_IMP(a_held_fits, clk, rst_n, held_r, rel_cnt <= OW'(fill_r))
  `SLDF_ASSERT_NXT(a_done_idle, clk, rst_n, state_r == S_DONE, state_r == S_IDLE)

endmodule

FILE: rtl/core/sync_length_checksum_deframer.sv
// ----------------------------------------------------------------------------
// sync_length_checksum_deframer
// Frame finder over a circular byte store with header, length and sum16.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one transfer per operation: push a byte, read a payload byte, or
//           release the held frame.
//   out_* : one status transfer per operation (ready flag, length, read byte,
//           overflow).
//   cfg_* : header word write, only while the block is idle.
// Push with a frame held, no-op, or a read outside the held frame: the engine
// goes straight to its done state, which registers out_tvalid; a payload read
// first waits in the sum-add state. Push or release without a held frame runs
// a scan (header issue and check per position, length check, sum issue and add
// per byte, checksum check) on the single read sequencer and two registered ports.
// One operation at a time; in_tready is low until the result is taken.
// Reset clears the store bookkeeping (empty store, no frame held) and loads
// header word 0xAA55; store contents need no clearing.
// A stalled receiver holds out_tdata and blocks new input transfers.
// ----------------------------------------------------------------------------
module sync_length_checksum_deframer #(
  parameter int STORE_DEPTH = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // mode[1:0], rx_byte[9:2], read_index[17:10]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // frame_ready[0], frame_length[8:1],
                                  // read_data[16:9], overflow[17]
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);
  import sldf_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);

  logic [15:0]   hdr_r;
  logic          out_valid_r;
  res_t          out_res_r;
  res_t          eng_res;
  logic          eng_idle, eng_done, in_xfer;
  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr0, rd_addr1;
  logic [7:0]    wr_data, rd_data0, rd_data1;

  assign in_tready = eng_idle && !out_valid_r;
  assign in_xfer   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r       <= HEADER_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        hdr_r <= cfg_wr_data;
      end
      if (eng_done) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (eng_done) begin
      out_res_r <= eng_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_res_r};

  sldf_engine #(.DEPTH(STORE_DEPTH), .AW(AW)) u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .hdr_word (hdr_r),
    .op_start (in_xfer),
    .op_mode  (mode_t'(in_tdata[1:0])),
    .op_byte  (in_tdata[9:2]),
    .op_idx   (in_tdata[17:10]),
    .idle     (eng_idle),
    .done     (eng_done),
    .res      (eng_res),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_addr0 (rd_addr0),
    .rd_addr1 (rd_addr1),
    .rd_data0 (rd_data0),
    .rd_data1 (rd_data1)
  );

  sldf_store #(.DEPTH(STORE_DEPTH), .AW(AW)) u_store (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_addr0 (rd_addr0),
    .rd_addr1 (rd_addr1),
    .rd_data0 (rd_data0),
    .rd_data1 (rd_data1)
  );

endmodule

FILE: tb/tb_sync_length_checksum_deframer.sv
// ----------------------------------------------------------------------------
// tb_sync_length_checksum_deframer
// Self-checking bench for the sync/length/checksum deframer. Pushes, reads,
// releases and no-ops are sent one transfer at a time. A local copy of the
// byte store, fill count and held frame predicts every status transfer.
// Directed frames, overflow, back-pressure hold-off and header word changes run;
// random frame traffic runs under varying sender idle and receiver stall rates.
// ----------------------------------------------------------------------------
module tb_sync_length_checksum_deframer;
  import sldf_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // mode[1:0], rx_byte[9:2], read_index[17:10]
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // frame_ready[0], frame_length[8:1],
                           // read_data[16:9], overflow[17]
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;

  sync_length_checksum_deframer i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // local copy of the block state
  logic [7:0]  store_mem [0:511];
  int          store_fill;
  int          held_start;
  bit          held_flag;
  logic [15:0] sync_word;

  res_t status_q[$];
  int   err_count;
  int   sent_count;
  int   sender_idle;
  int   recv_stall;
  int   hold_go;
  int   hold_seen;
  int   hold_left;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #80000000;
    $display("FAIL sync_length_checksum_deframer");
    $finish;
  end

  function automatic void shift_out(int cnt);
    if (cnt >= store_fill) begin
      store_fill = 0;
    end else if (cnt > 0) begin
      for (int i = 0; i < store_fill - cnt; i++) store_mem[i] = store_mem[i + cnt];
      store_fill -= cnt;
    end
  endfunction

  function automatic void search_frame();
    int pos;
    int len;
    int sum;
    int sent;
    bit found;
    pos = 0;
    found = 0;
    while (pos + 1 < store_fill && !found) begin
      if ({store_mem[pos + 1], store_mem[pos]} != sync_word) begin
        pos++;
      end else if (store_fill - pos < FRAME_OVERHEAD) begin
        break;
      end else begin
        len = store_mem[pos + 2];
        if (store_fill - pos < FRAME_OVERHEAD + len) break;
        sum = 0;
        for (int i = 0; i <= len; i++) sum = (sum + store_mem[pos + 2 + i]) & 16'hFFFF;
        sent = {store_mem[pos + 4 + len], store_mem[pos + 3 + len]};
        if (sum != sent) pos++;
        else found = 1;
      end
    end
    if (found) begin
      held_start = pos;
      held_flag = 1;
    end else begin
      shift_out(pos);
      held_start = 0;
      held_flag = 0;
    end
  endfunction

  function automatic res_t predict_status(mode_t m, logic [7:0] rx, logic [7:0] idx);
    res_t r;
    int   len;
    r = '0;
    case (m)
      MODE_PUSH: begin
        if (store_fill >= 512) begin
          r.overflow = 1'b1;
        end else begin
          store_mem[store_fill] = rx;
          store_fill++;
        end
        if (!held_flag) search_frame();
      end
      MODE_READ: begin
        if (held_flag) begin
          len = store_mem[held_start + 2];
          if (idx < len) r.read_data = store_mem[held_start + 3 + idx];
        end
      end
      MODE_RELEASE: begin
        if (held_flag) begin
          shift_out(held_start + FRAME_OVERHEAD + store_mem[held_start + 2]);
          held_flag = 0;
          held_start = 0;
        end
        search_frame();
      end
      default: ;
    endcase
    r.frame_ready = held_flag;
    r.frame_length = held_flag ? store_mem[held_start + 2] : 8'd0;
    return r;
  endfunction

  // receiver: random stall plus an occasional long hold-off
  always @(posedge clk) begin
    if (hold_go != hold_seen) begin
      hold_seen <= hold_go;
      hold_left <= 400;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = res_t'(out_tdata[17:0]);
      if (status_q.size() == 0) begin
        $error("unexpected status transfer %h", out_tdata);
        err_count++;
      end else begin
        want = status_q.pop_front();
        if (got.frame_ready !== want.frame_ready) begin
          $error("frame_ready: expected %0d actual %0d", want.frame_ready, got.frame_ready);
          err_count++;
        end
        if (got.frame_length !== want.frame_length) begin
          $error("frame_length: expected %0d actual %0d", want.frame_length,
                 got.frame_length);
          err_count++;
        end
        if (got.read_data !== want.read_data) begin
          $error("read_data: expected %0d actual %0d", want.read_data, got.read_data);
          err_count++;
        end
        if (got.overflow !== want.overflow) begin
          $error("overflow: expected %0d actual %0d", want.overflow, got.overflow);
          err_count++;
        end
      end
    end
  end

  task automatic send_op(mode_t m, logic [7:0] rx, logic [7:0] idx);
    if ($urandom_range(99) < sender_idle) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'd0, idx, rx, m};
    do @(posedge clk); while (!in_tready);
    status_q.push_back(predict_status(m, rx, idx));
    sent_count++;
  endtask

  task automatic push_byte(logic [7:0] b);
    send_op(MODE_PUSH, b, 8'($urandom_range(254)));
  endtask

  task automatic push_frame(int len, bit bad);
    logic [7:0]  pay;
    logic [15:0] sum;
    sum = 16'(len[7:0]);
    push_byte(sync_word[7:0]);
    push_byte(sync_word[15:8]);
    push_byte(len[7:0]);
    for (int i = 0; i < len; i++) begin
      pay = 8'($urandom_range(255));
      sum += 16'(pay);
      push_byte(pay);
    end
    if (bad) sum ^= 16'd1 << $urandom_range(15);
    push_byte(sum[7:0]);
    push_byte(sum[15:8]);
  endtask

  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_header(logic [15:0] v);
    wait_drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    sync_word = v;
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_directed();
    send_op(MODE_READ, 8'h00, 8'd0);
    send_op(MODE_RELEASE, 8'hFF, 8'd254);
    send_op(MODE_NOP, 8'hA5, 8'd1);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_frame(0, 0);
    send_op(MODE_READ, 8'h00, 8'd0);
    send_op(MODE_RELEASE, 8'h00, 8'd0);
    push_frame(3, 0);
    send_op(MODE_READ, 8'h00, 8'd2);
    send_op(MODE_READ, 8'h00, 8'd3);
    send_op(MODE_READ, 8'h00, 8'd254);
    push_byte(8'h55);
    send_op(MODE_RELEASE, 8'h00, 8'd0);
    // bad checksum frame, then a good one: rescan inside the failed bytes
    push_frame(1, 1);
    push_frame(0, 0);
    send_op(MODE_RELEASE, 8'h00, 8'd0);
  endtask

  task automatic test_overflow();
    push_frame(2, 0);
    for (int i = 0; i < 515; i++) push_byte(8'($urandom_range(255)));
    send_op(MODE_RELEASE, 8'h00, 8'd0);
    send_op(MODE_RELEASE, 8'h00, 8'd0);
  endtask

  task automatic test_backpressure();
    wait_drain();
    hold_go++;
    for (int i = 0; i < 20; i++) push_byte(8'($urandom_range(255)));
    push_frame(4, 0);
    send_op(MODE_RELEASE, 8'h00, 8'd0);
    wait_drain();
  endtask

  task automatic test_random(int n);
    int stop;
    int r;
    int len;
    stop = sent_count + n;
    while (sent_count < stop) begin
      r = $urandom_range(99);
      if (r < 60) begin
        len = ($urandom_range(19) == 0) ? $urandom_range(255) : $urandom_range(8);
        push_frame(len, $urandom_range(9) == 0);
        repeat ($urandom_range(3))
          send_op(MODE_READ, 8'($urandom_range(255)),
                  8'($urandom_range(1) ? $urandom_range(len > 0 ? len - 1 : 0)
                                       : $urandom_range(254)));
        if ($urandom_range(4) != 0)
          send_op(MODE_RELEASE, 8'($urandom_range(255)), 8'd0);
      end else if (r < 80) begin
        repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(255)));
      end else if (r < 90) begin
        send_op(MODE_RELEASE, 8'($urandom_range(255)), 8'($urandom_range(254)));
      end else begin
        send_op(mode_t'($urandom_range(3)), 8'($urandom_range(255)),
                8'($urandom_range(254)));
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    out_tready = 1'b0;
    err_count = 0;
    sent_count = 0;
    sender_idle = 0;
    recv_stall = 0;
    hold_go = 0;
    hold_seen = 0;
    hold_left = 0;
    store_fill = 0;
    held_start = 0;
    held_flag = 0;
    sync_word = HEADER_RESET;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_overflow();
    test_backpressure();
    write_header(16'hFFFF);
    test_directed();
    write_header(16'h0000);
    test_directed();
    write_header(HEADER_RESET);
    test_random(220);
    sender_idle = 74;
    write_header(16'($urandom_range(16'hFFFF)));
    test_random(220);
    sender_idle = 0;
    recv_stall = 74;
    write_header(16'hFFFF);
    test_random(220);
    sender_idle = 36;
    recv_stall = 36;
    write_header(16'h0000);
    test_random(220);

    wait_drain();
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("PASS sync_length_checksum_deframer");
    end else begin
      $display("FAIL sync_length_checksum_deframer");
    end
    $finish;
  end

endmodule
